// ===== hdl/max_pool_3d_window_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the 3D max pooling block
// Clocked property shorthands used by mp3w_back to check its logic.
// ----------------------------------------------------------------------------
`ifndef MAX_POOL_3D_WINDOW_ASSERT_SVH
`define MAX_POOL_3D_WINDOW_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MP3W_ASSERT_NOW(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("mp3w check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define MP3W_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("mp3w check failed one cycle later");

`endif

// ===== hdl/mp3w_pkg.sv =====
// ----------------------------------------------------------------------------
// mp3w_pkg
// Constants, register indexes and helpers shared by the max pooling block.
// ----------------------------------------------------------------------------
package mp3w_pkg;

    localparam int SLICE_BITS    = 12;
    localparam int CMP_BITS      = 14;
    localparam int COORD_BITS    = 6;
    localparam int CHAN_OUT_BITS = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;
    localparam int DEPTH_LIMIT   = 4096;
    localparam int STRIDE_LIMIT  = 3;
    localparam int NUM_SLOTS     = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_VOL_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VOL_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VOL_DEPTH     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_POOL_SIZE     = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_POOL_STRIDE   = 3'd5;

    typedef struct packed {
        logic [1:0] k;
    } t_pool_cfg;

    // Slot of the previous row or slice in a three-entry rotation.
    function automatic logic [1:0] slot_back1(input logic [1:0] slot);
        logic [1:0] res;
        case (slot)
            2'd0:    res = 2'd2;
            2'd1:    res = 2'd0;
            default: res = 2'd1;
        endcase
        return res;
    endfunction

    // Slot two rows or slices back.
    function automatic logic [1:0] slot_back2(input logic [1:0] slot);
        logic [1:0] res;
        case (slot)
            2'd0:    res = 2'd1;
            2'd1:    res = 2'd2;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] slot_next(input logic [1:0] slot);
        return (slot == 2'd2) ? 2'd0 : 2'(slot + 2'd1);
    endfunction

    function automatic logic [1:0] phase_next(input logic [1:0] ph, input logic [1:0] st);
        return (2'(ph + 2'd1) == st) ? 2'd0 : 2'(ph + 2'd1);
    endfunction

endpackage

// ===== hdl/mp3w_ram.sv =====
// ----------------------------------------------------------------------------
// mp3w_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mp3w_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mp3w_queue.sv =====
// ----------------------------------------------------------------------------
// mp3w_queue
// Small register FIFO between the classifying front and the pooling back end.
// ----------------------------------------------------------------------------
module mp3w_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_slot [DEPTH];
    logic [AW-1:0]    r_wptr, r_rptr;
    logic [AW:0]      r_count;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : AW'(r_wptr + 1'b1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : AW'(r_rptr + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= (AW+1)'(r_count + 1'b1);
            end else if (i_pop && !i_push) begin
                r_count <= (AW+1)'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

endmodule

// ===== hdl/mp3w_front.sv =====
// ----------------------------------------------------------------------------
// mp3w_front
// Configuration registers, position counters and window classification.
// ----------------------------------------------------------------------------
module mp3w_front import mp3w_pkg::*; #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_POOL     = 3,
    parameter int SAMPLE_BITS  = 16,
    parameter int CHB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int CB  = $clog2(MAX_WIDTH),
    parameter int RB  = $clog2(MAX_HEIGHT),
    parameter int IW  = SAMPLE_BITS + CHB + CB + RB + 6 + CB + RB + SLICE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    input  logic                     i_q_full,
    output logic                     o_push,
    output logic [IW-1:0]            o_item,
    output t_pool_cfg                o_cfg
);

    logic [6:0]  r_vol_width, r_vol_height;
    logic [12:0] r_vol_depth;
    logic [3:0]  r_channel_count;
    logic [1:0]  r_pool_size, r_pool_stride;

    logic [CMP_BITS-1:0] w_e, h_e, d_e, nc_e, k_e, st_e;

    logic [CHB-1:0]        r_ch, ch, n_ch;
    logic [CB-1:0]         r_col, col, n_col, r_ocol, ocol, n_ocol;
    logic [RB-1:0]         r_row, row, n_row, r_orow, orow, n_orow;
    logic [SLICE_BITS-1:0] r_slc, slc, n_slc, r_oslc, oslc, n_oslc;
    logic [1:0] r_phc, phc, n_phc, r_phr, phr, n_phr, r_phs, phs, n_phs;
    logic [1:0] r_r3, r3, n_r3, r_s3, s3, n_s3;
    logic       bad, ok_c, ok_r, ok_s, emit, last, accept, cfg_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol_width     <= 7'd64;
            r_vol_height    <= 7'd64;
            r_vol_depth     <= 13'd64;
            r_channel_count <= 4'd8;
            r_pool_size     <= 2'd2;
            r_pool_stride   <= 2'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_VOL_WIDTH:     r_vol_width     <= i_cfg_data[6:0];
                REG_VOL_HEIGHT:    r_vol_height    <= i_cfg_data[6:0];
                REG_VOL_DEPTH:     r_vol_depth     <= i_cfg_data;
                REG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[3:0];
                REG_POOL_SIZE:     r_pool_size     <= i_cfg_data[1:0];
                REG_POOL_STRIDE:   r_pool_stride   <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [CMP_BITS-1:0] clamp(input logic [CMP_BITS-1:0] v,
                                                   input logic [CMP_BITS-1:0] hi);
        if (v == '0) return CMP_BITS'(1);
        return (v > hi) ? hi : v;
    endfunction

    assign w_e  = clamp(CMP_BITS'(r_vol_width), CMP_BITS'(MAX_WIDTH));
    assign h_e  = clamp(CMP_BITS'(r_vol_height), CMP_BITS'(MAX_HEIGHT));
    assign d_e  = clamp(CMP_BITS'(r_vol_depth), CMP_BITS'(DEPTH_LIMIT));
    assign nc_e = clamp(CMP_BITS'(r_channel_count), CMP_BITS'(MAX_CHANNELS));
    assign k_e  = clamp(CMP_BITS'(r_pool_size), CMP_BITS'(MAX_POOL));
    assign st_e = clamp(CMP_BITS'(r_pool_stride), CMP_BITS'(STRIDE_LIMIT));

    assign o_cfg.k     = k_e[1:0];
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !i_q_full;
    assign accept      = i_in_valid && !i_q_full;
    assign o_push      = accept;

    // Only a write to an existing register starts a new volume.
    assign cfg_restart = i_cfg_valid && (i_cfg_index <= REG_POOL_STRIDE);

    // Counters out of range can only follow a register change; start over.
    assign bad = (CMP_BITS'(r_ch) >= nc_e) || (CMP_BITS'(r_col) >= w_e) ||
                 (CMP_BITS'(r_row) >= h_e) || (CMP_BITS'(r_slc) >= d_e);

    assign ch   = bad ? '0 : r_ch;
    assign col  = bad ? '0 : r_col;
    assign row  = bad ? '0 : r_row;
    assign slc  = bad ? '0 : r_slc;
    assign ocol = bad ? '0 : r_ocol;
    assign orow = bad ? '0 : r_orow;
    assign oslc = bad ? '0 : r_oslc;
    assign phc  = bad ? '0 : r_phc;
    assign phr  = bad ? '0 : r_phr;
    assign phs  = bad ? '0 : r_phs;
    assign r3   = bad ? '0 : r_r3;
    assign s3   = bad ? '0 : r_s3;

    assign ok_c = (CMP_BITS'(col) + 1'b1) >= k_e;
    assign ok_r = (CMP_BITS'(row) + 1'b1) >= k_e;
    assign ok_s = (CMP_BITS'(slc) + 1'b1) >= k_e;
    assign emit = ok_c && ok_r && ok_s && (phc == '0) && (phr == '0) && (phs == '0);

    // The last origin on an axis is the one after which a further stride no longer fits.
    assign last = ((CMP_BITS'(ch) + 1'b1) >= nc_e) &&
                  ((CMP_BITS'(col) + st_e) >= w_e) &&
                  ((CMP_BITS'(row) + st_e) >= h_e) &&
                  ((CMP_BITS'(slc) + st_e) >= d_e);

    always_comb begin
        n_ch = ch;  n_col = col;  n_row = row;  n_slc = slc;
        n_ocol = ocol; n_orow = orow; n_oslc = oslc;
        n_phc = phc; n_phr = phr; n_phs = phs; n_r3 = r3; n_s3 = s3;
        if ((CMP_BITS'(ch) + 1'b1) < nc_e) begin
            n_ch = CHB'(ch + 1'b1);
        end else begin
            n_ch = '0;
            if ((CMP_BITS'(col) + 1'b1) < w_e) begin
                n_col = CB'(col + 1'b1);
                if (ok_c) begin
                    n_phc = phase_next(phc, st_e[1:0]);
                    if (n_phc == '0) n_ocol = CB'(ocol + 1'b1);
                end
            end else begin
                n_col = '0; n_phc = '0; n_ocol = '0;
                if ((CMP_BITS'(row) + 1'b1) < h_e) begin
                    n_row = RB'(row + 1'b1);
                    n_r3  = slot_next(r3);
                    if (ok_r) begin
                        n_phr = phase_next(phr, st_e[1:0]);
                        if (n_phr == '0) n_orow = RB'(orow + 1'b1);
                    end
                end else begin
                    n_row = '0; n_phr = '0; n_orow = '0; n_r3 = '0;
                    if ((CMP_BITS'(slc) + 1'b1) < d_e) begin
                        n_slc = SLICE_BITS'(slc + 1'b1);
                        n_s3  = slot_next(s3);
                        if (ok_s) begin
                            n_phs = phase_next(phs, st_e[1:0]);
                            if (n_phs == '0) n_oslc = SLICE_BITS'(oslc + 1'b1);
                        end
                    end else begin
                        n_slc = '0; n_phs = '0; n_oslc = '0; n_s3 = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_ch <= '0; r_col <= '0; r_row <= '0; r_slc <= '0;
            r_ocol <= '0; r_orow <= '0; r_oslc <= '0;
            r_phc <= '0; r_phr <= '0; r_phs <= '0; r_r3 <= '0; r_s3 <= '0;
        end else if (accept) begin
            r_ch <= n_ch; r_col <= n_col; r_row <= n_row; r_slc <= n_slc;
            r_ocol <= n_ocol; r_orow <= n_orow; r_oslc <= n_oslc;
            r_phc <= n_phc; r_phr <= n_phr; r_phs <= n_phs; r_r3 <= n_r3; r_s3 <= n_s3;
        end
    end

    assign o_item = {i_sample, ch, col, row, r3, s3, emit, last, ocol, orow, oslc};

endmodule

// ===== hdl/mp3w_back.sv =====
// ----------------------------------------------------------------------------
// mp3w_back
// Separable max pipeline: column registers, row store, slice store, output.
// ----------------------------------------------------------------------------
module mp3w_back import mp3w_pkg::*; #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int SAMPLE_BITS  = 16,
    parameter int CHB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1,
    parameter int CB  = $clog2(MAX_WIDTH),
    parameter int RB  = $clog2(MAX_HEIGHT),
    parameter int IW  = SAMPLE_BITS + CHB + CB + RB + 6 + CB + RB + SLICE_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_pool_cfg                i_cfg,
    input  logic [IW-1:0]            i_item,
    input  logic                     i_q_empty,
    output logic                     o_pop,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [SAMPLE_BITS-1:0]   o_max_value,
    output logic [CHAN_OUT_BITS-1:0] o_channel,
    output logic [SLICE_BITS-1:0]    o_out_slice,
    output logic [COORD_BITS-1:0]    o_out_row,
    output logic [COORD_BITS-1:0]    o_out_col,
    output logic                     o_volume_end
);

    `include "max_pool_3d_window_assert.svh"

    localparam int RAW = CB + CHB;
    localparam int PAW = RB + CB + CHB;
    localparam logic [SAMPLE_BITS-1:0] MIN_CODE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [SAMPLE_BITS-1:0] h_sample;
    logic [CHB-1:0]         h_ch;
    logic [CB-1:0]          h_col, h_ocol;
    logic [RB-1:0]          h_row, h_orow;
    logic [1:0]             h_r3, h_s3;
    logic                   h_emit, h_last;
    logic [SLICE_BITS-1:0]  h_oslc;

    assign {h_sample, h_ch, h_col, h_row, h_r3, h_s3, h_emit, h_last,
            h_ocol, h_orow, h_oslc} = i_item;

    logic en, k2, k3;
    assign en    = !o_out_valid || i_out_ready;
    assign o_pop = en && !i_q_empty;
    assign k2    = i_cfg.k >= 2'd2;
    assign k3    = i_cfg.k >= 2'd3;

    function automatic logic [SAMPLE_BITS-1:0] smax(input logic [SAMPLE_BITS-1:0] a,
                                                    input logic [SAMPLE_BITS-1:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    // Stage 0: max along the columns from the per-channel history.
    logic [SAMPLE_BITS-1:0] r_prev1 [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] r_prev2 [MAX_CHANNELS];
    logic [SAMPLE_BITS-1:0] hmax;

    assign hmax = smax(h_sample, smax(k2 ? r_prev1[h_ch] : MIN_CODE,
                                      k3 ? r_prev2[h_ch] : MIN_CODE));

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prev1[h_ch] <= h_sample;
            r_prev2[h_ch] <= r_prev1[h_ch];
        end
    end

    logic [RAW-1:0]         row_addr;
    logic [SAMPLE_BITS-1:0] row_rd [NUM_SLOTS];
    assign row_addr = {h_col, h_ch};

    for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_row
        mp3w_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2**RAW)) u_row_ram (
            .i_clk  (i_clk),
            .i_we   (o_pop && (h_r3 == 2'(j))),
            .i_waddr(row_addr),
            .i_wdata(hmax),
            .i_re   (o_pop),
            .i_raddr(row_addr),
            .o_rdata(row_rd[j])
        );
    end

    // Stage 1: max across rows, then into the slice store.
    logic                   r_v1, r_emit1, r_last1;
    logic [SAMPLE_BITS-1:0] r_hmax1;
    logic [PAW-1:0]         r_paddr1;
    logic [1:0]             r_r3_1, r_s3_1;
    logic [CHB-1:0]         r_ch1;
    logic [CB-1:0]          r_ocol1;
    logic [RB-1:0]          r_orow1;
    logic [SLICE_BITS-1:0]  r_oslc1;
    logic [SAMPLE_BITS-1:0] vmax;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_emit1  <= h_emit;
            r_last1  <= h_last;
            r_hmax1  <= hmax;
            r_paddr1 <= {h_row, h_col, h_ch};
            r_r3_1   <= h_r3;
            r_s3_1   <= h_s3;
            r_ch1    <= h_ch;
            r_ocol1  <= h_ocol;
            r_orow1  <= h_orow;
            r_oslc1  <= h_oslc;
        end
    end

    assign vmax = smax(r_hmax1, smax(k2 ? row_rd[slot_back1(r_r3_1)] : MIN_CODE,
                                     k3 ? row_rd[slot_back2(r_r3_1)] : MIN_CODE));

    logic [SAMPLE_BITS-1:0] pl_rd [NUM_SLOTS];

    for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_plane
        mp3w_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(2**PAW)) u_plane_ram (
            .i_clk  (i_clk),
            .i_we   (en && r_v1 && (r_s3_1 == 2'(j))),
            .i_waddr(r_paddr1),
            .i_wdata(vmax),
            .i_re   (en),
            .i_raddr(r_paddr1),
            .o_rdata(pl_rd[j])
        );
    end

    // Stage 2: max across slices.
    logic                   r_v2, r_emit2, r_last2;
    logic [SAMPLE_BITS-1:0] r_vmax2, wmax;
    logic [1:0]             r_s3_2;
    logic [CHB-1:0]         r_ch2;
    logic [CB-1:0]          r_ocol2;
    logic [RB-1:0]          r_orow2;
    logic [SLICE_BITS-1:0]  r_oslc2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_emit2 <= r_emit1;
            r_last2 <= r_last1;
            r_vmax2 <= vmax;
            r_s3_2  <= r_s3_1;
            r_ch2   <= r_ch1;
            r_ocol2 <= r_ocol1;
            r_orow2 <= r_orow1;
            r_oslc2 <= r_oslc1;
        end
    end

    assign wmax = smax(r_vmax2, smax(k2 ? pl_rd[slot_back1(r_s3_2)] : MIN_CODE,
                                     k3 ? pl_rd[slot_back2(r_s3_2)] : MIN_CODE));

    // Output register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v2 && r_emit2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_max_value  <= wmax;
            o_channel    <= CHAN_OUT_BITS'(r_ch2);
            o_out_slice  <= r_oslc2;
            o_out_row    <= COORD_BITS'(r_orow2);
            o_out_col    <= COORD_BITS'(r_ocol2);
            o_volume_end <= r_last2;
        end
    end

    assign o_out_valid = r_out_valid;

    `MP3W_ASSERT_NEXT(a_pop_fills_stage1, i_clk, i_rst_n, o_pop, r_v1)
    `MP3W_ASSERT_NEXT(a_stage1_held_on_stall, i_clk, i_rst_n, r_v1 && !en, r_v1)
    `MP3W_ASSERT_NEXT(a_window_reaches_output, i_clk, i_rst_n, en && r_v2 && r_emit2,
                      r_out_valid)
    `MP3W_ASSERT_NOW(a_no_pop_on_stall, i_clk, i_rst_n, !en, !o_pop)

endmodule

// ===== hdl/max_pool_3d_window.sv =====
// ----------------------------------------------------------------------------
// max_pool_3d_window
// Streaming 3D max pooling. One signed sample is taken per clock, in slice, row,
// column order with channels fastest, and the sample that completes a window
// reaches its pooled result through the FIFO, the stage 1 and stage 2 registers
// and the output register; the sustained rate is one item per cycle, and the
// input stalls only when result back-pressure has filled the four-entry FIFO
// and the pipeline behind it. The maximum is built in three passes: per-channel
// registers over columns, a row store of three rotating row slots, and a slice
// store of three rotating slices. The stores need no clearing after reset, so
// the block is ready at once. A small FIFO decouples input acceptance from result
// back-pressure; a write to any defined register restarts the volume.
// ----------------------------------------------------------------------------
module max_pool_3d_window import mp3w_pkg::*; #(
    parameter int MAX_CHANNELS = 8,
    parameter int MAX_WIDTH    = 64,
    parameter int MAX_HEIGHT   = 64,
    parameter int MAX_POOL     = 3,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [SAMPLE_BITS-1:0]   i_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [SAMPLE_BITS-1:0]   o_max_value,
    output logic [CHAN_OUT_BITS-1:0] o_channel,
    output logic [SLICE_BITS-1:0]    o_out_slice,
    output logic [COORD_BITS-1:0]    o_out_row,
    output logic [COORD_BITS-1:0]    o_out_col,
    output logic                     o_volume_end
);

    localparam int CHB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int RB  = $clog2(MAX_HEIGHT);
    localparam int IW  = SAMPLE_BITS + CHB + CB + RB + 6 + CB + RB + SLICE_BITS;

    logic          q_full, q_empty, push, pop;
    logic [IW-1:0] item_in, item_out;
    t_pool_cfg     cfg;

    mp3w_front #(
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .MAX_POOL(MAX_POOL), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_sample(i_sample),
        .i_q_full(q_full), .o_push(push), .o_item(item_in), .o_cfg(cfg)
    );

    mp3w_queue #(.WIDTH(IW), .DEPTH(4)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data(item_in), .i_pop(pop),
        .o_data(item_out), .o_full(q_full), .o_empty(q_empty)
    );

    mp3w_back #(
        .MAX_CHANNELS(MAX_CHANNELS), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(cfg),
        .i_item(item_out), .i_q_empty(q_empty), .o_pop(pop),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_max_value(o_max_value), .o_channel(o_channel),
        .o_out_slice(o_out_slice), .o_out_row(o_out_row),
        .o_out_col(o_out_col), .o_volume_end(o_volume_end)
    );

endmodule
